[src/wpsd_pkg.sv]
// Shared types and constants for the WAV PCM stream decoder.
package wpsd_pkg;

  localparam int PHASE_W = 5;

  localparam logic [PHASE_W-1:0] PH_RIFF       = 5'd0;
  localparam logic [PHASE_W-1:0] PH_RIFFSIZE   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_WAVE       = 5'd2;
  localparam logic [PHASE_W-1:0] PH_FMTID      = 5'd3;
  localparam logic [PHASE_W-1:0] PH_FMTSKIPSZ  = 5'd4;
  localparam logic [PHASE_W-1:0] PH_FMTSKIP    = 5'd5;
  localparam logic [PHASE_W-1:0] PH_FMTSIZE    = 5'd6;
  localparam logic [PHASE_W-1:0] PH_FORMAT     = 5'd7;
  localparam logic [PHASE_W-1:0] PH_CHANNELS   = 5'd8;
  localparam logic [PHASE_W-1:0] PH_RATE       = 5'd9;
  localparam logic [PHASE_W-1:0] PH_BYTERATE   = 5'd10;
  localparam logic [PHASE_W-1:0] PH_ALIGN      = 5'd11;
  localparam logic [PHASE_W-1:0] PH_BITS       = 5'd12;
  localparam logic [PHASE_W-1:0] PH_DATAID     = 5'd13;
  localparam logic [PHASE_W-1:0] PH_DATASKIPSZ = 5'd14;
  localparam logic [PHASE_W-1:0] PH_DATASKIP   = 5'd15;
  localparam logic [PHASE_W-1:0] PH_DATASIZE   = 5'd16;
  localparam logic [PHASE_W-1:0] PH_SAMPLES    = 5'd17;
  localparam logic [PHASE_W-1:0] PH_DONE       = 5'd18;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_FORMAT   = 2'd0;
  localparam logic [1:0] ERR_CHANNELS = 2'd1;
  localparam logic [1:0] ERR_DEPTH    = 2'd2;
  localparam logic [1:0] ERR_END      = 2'd3;

  localparam logic [1:0] TAG_SEL_RIFF = 2'd0;
  localparam logic [1:0] TAG_SEL_WAVE = 2'd1;
  localparam logic [1:0] TAG_SEL_FMT  = 2'd2;
  localparam logic [1:0] TAG_SEL_DATA = 2'd3;

  // Tags are stored with the first character in the low byte.
  localparam logic [31:0] TAG_RIFF = {"F", "F", "I", "R"};
  localparam logic [31:0] TAG_WAVE = {"E", "V", "A", "W"};
  localparam logic [31:0] TAG_FMT  = {" ", "t", "m", "f"};
  localparam logic [31:0] TAG_DATA = {"a", "t", "a", "d"};

  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [31:0] PCM_FORMAT     = 32'd1;
  localparam logic [31:0] BYTE_BIAS      = 32'h7fffffff;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] sample_bits;
    logic [1:0]  channel_count;
    logic [31:0] rate_hz;
    logic [5:0]  depth_bits;
    logic [1:0]  error_code;
  } wpsd_result_t;

  function automatic logic [7:0] tag_byte(input logic [1:0] sel, input logic [1:0] pos);
    logic [31:0] word;
    unique case (sel)
      TAG_SEL_RIFF: word = TAG_RIFF;
      TAG_SEL_WAVE: word = TAG_WAVE;
      TAG_SEL_FMT:  word = TAG_FMT;
      default:      word = TAG_DATA;
    endcase
    return word[{pos, 3'b000} +: 8];
  endfunction

endpackage

[src/wpsd_core.sv]
// Parser state and the per-byte state update of the WAV PCM stream decoder.
module wpsd_core import wpsd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   in_byte,
  input  logic         is_last,
  output wpsd_result_t result
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [1:0]         fidx, fidx_next;
  logic [31:0]        facc, facc_next;
  logic               tag_ok, tag_ok_next;
  logic [31:0]        skip_left, skip_left_next;
  logic [1:0]         st_ch, st_ch_next;
  logic [31:0]        st_rate, st_rate_next;
  logic [5:0]         st_depth, st_depth_next;
  logic [31:0]        data_left, data_left_next;
  logic [31:0]        sacc, sacc_next;
  logic               failed, failed_next;

  logic [1:0]  tag_sel;
  logic        tag_ok_new;
  logic [31:0] acc_new;
  logic [31:0] sample_new;
  logic [31:0] left_dec;
  logic [31:0] decoded;
  logic [2:0]  bpp;
  logic        two_byte;
  logic        field_done;
  logic        sample_done;
  logic        end_error;

  assign acc_new    = facc | (32'(in_byte) << {fidx, 3'b000});
  assign sample_new = sacc | (32'(in_byte) << {fidx, 3'b000});
  assign left_dec   = data_left - 32'd1;
  assign bpp        = st_depth[5:3];
  assign two_byte   = (phase == PH_FORMAT) || (phase == PH_CHANNELS) ||
                      (phase == PH_ALIGN) || (phase == PH_BITS);
  assign field_done = two_byte ? (fidx == 2'd1) : (fidx == 2'd3);
  assign sample_done = ({1'b0, fidx} + 3'd1) >= bpp;

  always_comb begin
    unique case (phase)
      PH_RIFF:  tag_sel = TAG_SEL_RIFF;
      PH_WAVE:  tag_sel = TAG_SEL_WAVE;
      PH_FMTID: tag_sel = TAG_SEL_FMT;
      default:  tag_sel = TAG_SEL_DATA;
    endcase
  end

  assign tag_ok_new = tag_ok && (in_byte == tag_byte(tag_sel, fidx));

  // The 8-bit case reproduces the stored offset-binary convention.
  always_comb begin
    unique case (bpp)
      3'd1:    decoded = {{24{sample_new[7]}}, sample_new[7:0]} + BYTE_BIAS;
      3'd2:    decoded = {{16{sample_new[15]}}, sample_new[15:0]};
      3'd3:    decoded = {{8{sample_new[23]}}, sample_new[23:0]};
      default: decoded = sample_new;
    endcase
  end

  always_comb begin
    phase_next     = phase;
    fidx_next      = fidx;
    facc_next      = facc;
    tag_ok_next    = tag_ok;
    skip_left_next = skip_left;
    st_ch_next     = st_ch;
    st_rate_next   = st_rate;
    st_depth_next  = st_depth;
    data_left_next = data_left;
    sacc_next      = sacc;
    failed_next    = failed;
    result         = '0;
    end_error      = 1'b0;

    if (step) begin
      if (!failed) begin
        unique case (phase)
          PH_RIFF, PH_WAVE, PH_FMTID, PH_DATAID: begin
            if (fidx == 2'd3) begin
              fidx_next   = 2'd0;
              tag_ok_next = 1'b1;
              unique case (phase)
                PH_RIFF: begin
                  if (tag_ok_new) phase_next = PH_RIFFSIZE;
                  else begin
                    failed_next       = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_FORMAT;
                  end
                end
                PH_WAVE: begin
                  if (tag_ok_new) phase_next = PH_FMTID;
                  else begin
                    failed_next       = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_FORMAT;
                  end
                end
                PH_FMTID: phase_next = tag_ok_new ? PH_FMTSIZE : PH_FMTSKIPSZ;
                default:  phase_next = tag_ok_new ? PH_DATASIZE : PH_DATASKIPSZ;
              endcase
            end else begin
              fidx_next   = fidx + 2'd1;
              tag_ok_next = tag_ok_new;
            end
          end

          PH_RIFFSIZE, PH_FMTSKIPSZ, PH_DATASKIPSZ, PH_FMTSIZE, PH_FORMAT, PH_CHANNELS,
          PH_RATE, PH_BYTERATE, PH_ALIGN, PH_BITS, PH_DATASIZE: begin
            if (field_done) begin
              facc_next = '0;
              fidx_next = 2'd0;
              unique case (phase)
                PH_RIFFSIZE: phase_next = PH_WAVE;
                PH_FMTSKIPSZ: begin
                  skip_left_next = acc_new;
                  phase_next     = (acc_new == '0) ? PH_FMTID : PH_FMTSKIP;
                end
                PH_DATASKIPSZ: begin
                  skip_left_next = acc_new;
                  phase_next     = (acc_new == '0) ? PH_DATAID : PH_DATASKIP;
                end
                PH_FMTSIZE: begin
                  if (acc_new == FMT_CHUNK_SIZE) phase_next = PH_FORMAT;
                  else begin
                    failed_next       = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_FORMAT;
                  end
                end
                PH_FORMAT: begin
                  if (acc_new == PCM_FORMAT) phase_next = PH_CHANNELS;
                  else begin
                    failed_next       = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_FORMAT;
                  end
                end
                PH_CHANNELS: begin
                  if (acc_new == 32'd1 || acc_new == 32'd2) begin
                    st_ch_next = acc_new[1:0];
                    phase_next = PH_RATE;
                  end else begin
                    failed_next       = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_CHANNELS;
                  end
                end
                PH_RATE: begin
                  st_rate_next = acc_new;
                  phase_next   = PH_BYTERATE;
                end
                PH_BYTERATE: phase_next = PH_ALIGN;
                PH_ALIGN:    phase_next = PH_BITS;
                PH_BITS: begin
                  if (acc_new == 32'd8 || acc_new == 32'd16 || acc_new == 32'd24 ||
                      acc_new == 32'd32) begin
                    st_depth_next = acc_new[5:0];
                    phase_next    = PH_DATAID;
                  end else begin
                    failed_next       = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_DEPTH;
                  end
                end
                default: begin
                  // Data size: the raw size is kept and the parse ends once less
                  // than one whole sample remains, which drops a partial tail.
                  data_left_next       = acc_new;
                  sacc_next            = '0;
                  phase_next           = (acc_new < 32'(bpp)) ? PH_DONE : PH_SAMPLES;
                  result.valid         = 1'b1;
                  result.kind          = KIND_FORMAT;
                  result.channel_count = st_ch;
                  result.rate_hz       = st_rate;
                  result.depth_bits    = st_depth;
                end
              endcase
            end else begin
              facc_next = acc_new;
              fidx_next = fidx + 2'd1;
            end
          end

          PH_FMTSKIP, PH_DATASKIP: begin
            skip_left_next = skip_left - 32'd1;
            if (skip_left == 32'd1) phase_next = (phase == PH_FMTSKIP) ? PH_FMTID : PH_DATAID;
          end

          PH_SAMPLES: begin
            data_left_next = left_dec;
            if (sample_done) begin
              fidx_next          = 2'd0;
              sacc_next          = '0;
              if (left_dec < 32'(bpp)) phase_next = PH_DONE;
              result.valid       = 1'b1;
              result.kind        = KIND_SAMPLE;
              result.sample_bits = decoded;
            end else begin
              fidx_next = fidx + 2'd1;
              sacc_next = sample_new;
            end
          end

          default: begin
          end
        endcase
      end

      if (is_last) begin
        end_error = !failed && !failed_next && (phase_next != PH_DONE);
        if (end_error) begin
          result            = '0;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_END;
        end
        phase_next     = PH_RIFF;
        fidx_next      = 2'd0;
        facc_next      = '0;
        tag_ok_next    = 1'b1;
        skip_left_next = '0;
        st_ch_next     = '0;
        st_rate_next   = '0;
        st_depth_next  = '0;
        data_left_next = '0;
        sacc_next      = '0;
        failed_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RIFF;
      fidx      <= 2'd0;
      facc      <= '0;
      tag_ok    <= 1'b1;
      skip_left <= '0;
      st_ch     <= '0;
      st_rate   <= '0;
      st_depth  <= '0;
      data_left <= '0;
      sacc      <= '0;
      failed    <= 1'b0;
    end else begin
      phase     <= phase_next;
      fidx      <= fidx_next;
      facc      <= facc_next;
      tag_ok    <= tag_ok_next;
      skip_left <= skip_left_next;
      st_ch     <= st_ch_next;
      st_rate   <= st_rate_next;
      st_depth  <= st_depth_next;
      data_left <= data_left_next;
      sacc      <= sacc_next;
      failed    <= failed_next;
    end
  end

  // The parser only enters the failed state while the header is parsed.
  a_failed_in_header: assert property (@(posedge clk) disable iff (rst)
    failed |-> (phase != PH_SAMPLES) && (phase != PH_DONE))
    else $error("parser failed after the header was accepted");

  a_depth_in_samples: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SAMPLES) |->
      (st_depth == 6'd8 || st_depth == 6'd16 || st_depth == 6'd24 || st_depth == 6'd32))
    else $error("sample phase entered with an unsupported depth");

  a_restart_on_last: assert property (@(posedge clk) disable iff (rst)
    step && is_last |=> (phase == PH_RIFF) && !failed && (fidx == 2'd0))
    else $error("parser did not restart after the final byte");

endmodule

[src/wav_pcm_stream_decoder.sv]
// Top level of the WAV PCM stream decoder: input stage, parser core and result stage.
// The decoder takes one file byte per cycle while neither side stalls: a byte is
// captured in the input register, then the parser core updates its state from it
// and loads any result into the output register. Each byte yields at most
// one item: format information once the data size is read, one sample per whole
// sample of the data chunk, or an error code; the parser restarts after the byte
// flagged as last. Both sides may stall at any time; the input register only holds
// when the output register is full and stalled.
module wav_pcm_stream_decoder import wpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] sample_bits,
  output logic [1:0]  channel_count,
  output logic [31:0] rate_hz,
  output logic [5:0]  depth_bits,
  output logic [1:0]  error_code
);

  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         hold_last;
  logic         advance;
  logic         in_take;
  wpsd_result_t result;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte <= in_byte;
      hold_last <= is_last;
    end
  end

  wpsd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (hold_byte),
    .is_last (hold_last),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      kind          <= result.kind;
      sample_bits   <= result.sample_bits;
      channel_count <= result.channel_count;
      rate_hz       <= result.rate_hz;
      depth_bits    <= result.depth_bits;
      error_code    <= result.error_code;
    end
  end

  // The input side only stalls when a byte is waiting behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !advance)
    else $error("parser stepped while its result was still held");

endmodule

[test/wav_pcm_stream_decoder_tb.sv]
// Self-checking testbench for the WAV PCM stream decoder with a built-in parser predictor.
module wav_pcm_stream_decoder_tb;
  import wpsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_TARGET    = 2000;
  localparam int QUIET_TAIL     = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {TAG_PENDING, TAG_HIT, TAG_MISS} tag_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_bits;
    logic [1:0]  channel_count;
    logic [31:0] rate_hz;
    logic [5:0]  depth_bits;
    logic [1:0]  error_code;
  } decoded_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       hold;
  } stream_byte_t;

  typedef struct {
    logic [31:0] riff_len;
    logic [31:0] fmt_len;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] depth;
    int          pre_chunks;
    int          mid_chunks;
    logic [31:0] data_len;
    int          data_present;
    logic        extreme_fill;
    int          cut_at;
    int          flip_at;
  } wav_spec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] sample_bits;
  logic [1:0]  channel_count;
  logic [31:0] rate_hz;
  logic [5:0]  depth_bits;
  logic [1:0]  error_code;

  stream_byte_t pending_bytes[$];
  decoded_t     decoded_q[$];
  logic [7:0]   file_bytes[$];

  logic in_taken = 1'b0;
  int   send_gap = 0;
  int   stall_gap = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;

  // Predictor state.
  logic [PHASE_W-1:0] ph;
  logic [1:0]         byte_idx;
  logic [31:0]        field_acc;
  logic               tag_ok;
  logic [31:0]        skip_cnt;
  logic [1:0]         fmt_chans;
  logic [31:0]        fmt_rate;
  logic [5:0]         fmt_depth;
  logic [31:0]        data_left;
  logic [31:0]        smp_acc;
  logic               parse_failed;

  wav_pcm_stream_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .sample_bits  (sample_bits),
    .channel_count(channel_count),
    .rate_hz      (rate_hz),
    .depth_bits   (depth_bits),
    .error_code   (error_code)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void restart_parser();
    ph           = PH_RIFF;
    byte_idx     = 2'd0;
    field_acc    = 32'd0;
    tag_ok       = 1'b1;
    skip_cnt     = 32'd0;
    fmt_chans    = 2'd0;
    fmt_rate     = 32'd0;
    fmt_depth    = 6'd0;
    data_left    = 32'd0;
    smp_acc      = 32'd0;
    parse_failed = 1'b0;
  endfunction

  function automatic tag_state_t tag_step(input logic [7:0] b, input logic [31:0] tag);
    int unsigned pos;
    pos = byte_idx;
    if (b != tag[8*pos +: 8]) tag_ok = 1'b0;
    if (pos == 3) begin
      tag_step = tag_ok ? TAG_HIT : TAG_MISS;
      byte_idx = 2'd0;
      tag_ok   = 1'b1;
    end else begin
      tag_step = TAG_PENDING;
      byte_idx = 2'(pos + 1);
    end
  endfunction

  function automatic logic field_step(input logic [7:0] b, input int unsigned nbytes,
                                      output logic [31:0] v);
    int unsigned pos;
    pos = byte_idx;
    v = 32'd0;
    field_acc = field_acc | (32'(b) << (8 * pos));
    if (pos + 1 >= nbytes) begin
      v         = field_acc;
      field_acc = 32'd0;
      byte_idx  = 2'd0;
      return 1'b1;
    end
    byte_idx = 2'(pos + 1);
    return 1'b0;
  endfunction

  function automatic decoded_t flag_error(input logic [1:0] code);
    decoded_t r;
    parse_failed = 1'b1;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  // Advances the parser by one file byte and queues the item it should produce, if any.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    decoded_t    r;
    logic        hit;
    logic        was_failed;
    logic        is_fmt;
    tag_state_t  t;
    logic [31:0] v;
    logic [31:0] n;
    int unsigned bpp;
    int unsigned pos;
    r          = '0;
    hit        = 1'b0;
    was_failed = parse_failed;
    if (!parse_failed) begin
      case (ph)
        PH_RIFF, PH_WAVE: begin
          t = tag_step(b, (ph == PH_RIFF) ? TAG_RIFF : TAG_WAVE);
          if (t == TAG_MISS) begin
            r   = flag_error(ERR_FORMAT);
            hit = 1'b1;
          end else if (t == TAG_HIT) begin
            ph = (ph == PH_RIFF) ? PH_RIFFSIZE : PH_FMTID;
          end
        end
        PH_RIFFSIZE: if (field_step(b, 4, v)) ph = PH_WAVE;
        PH_FMTID, PH_DATAID: begin
          is_fmt = (ph == PH_FMTID);
          t = tag_step(b, is_fmt ? TAG_FMT : TAG_DATA);
          if (t == TAG_HIT) ph = is_fmt ? PH_FMTSIZE : PH_DATASIZE;
          else if (t == TAG_MISS) ph = is_fmt ? PH_FMTSKIPSZ : PH_DATASKIPSZ;
        end
        PH_FMTSKIPSZ, PH_DATASKIPSZ: begin
          if (field_step(b, 4, v)) begin
            is_fmt   = (ph == PH_FMTSKIPSZ);
            skip_cnt = v;
            if (v == 32'd0) ph = is_fmt ? PH_FMTID : PH_DATAID;
            else ph = is_fmt ? PH_FMTSKIP : PH_DATASKIP;
          end
        end
        PH_FMTSKIP, PH_DATASKIP: begin
          skip_cnt = skip_cnt - 32'd1;
          if (skip_cnt == 32'd0) ph = (ph == PH_FMTSKIP) ? PH_FMTID : PH_DATAID;
        end
        PH_FMTSIZE: begin
          if (field_step(b, 4, v)) begin
            if (v != FMT_CHUNK_SIZE) begin
              r   = flag_error(ERR_FORMAT);
              hit = 1'b1;
            end else begin
              ph = PH_FORMAT;
            end
          end
        end
        PH_FORMAT: begin
          if (field_step(b, 2, v)) begin
            if (v != PCM_FORMAT) begin
              r   = flag_error(ERR_FORMAT);
              hit = 1'b1;
            end else begin
              ph = PH_CHANNELS;
            end
          end
        end
        PH_CHANNELS: begin
          if (field_step(b, 2, v)) begin
            if (v != 32'd1 && v != 32'd2) begin
              r   = flag_error(ERR_CHANNELS);
              hit = 1'b1;
            end else begin
              fmt_chans = v[1:0];
              ph        = PH_RATE;
            end
          end
        end
        PH_RATE: begin
          if (field_step(b, 4, v)) begin
            fmt_rate = v;
            ph       = PH_BYTERATE;
          end
        end
        PH_BYTERATE: if (field_step(b, 4, v)) ph = PH_ALIGN;
        PH_ALIGN: if (field_step(b, 2, v)) ph = PH_BITS;
        PH_BITS: begin
          if (field_step(b, 2, v)) begin
            if (v != 32'd8 && v != 32'd16 && v != 32'd24 && v != 32'd32) begin
              r   = flag_error(ERR_DEPTH);
              hit = 1'b1;
            end else begin
              fmt_depth = v[5:0];
              ph        = PH_DATAID;
            end
          end
        end
        PH_DATASIZE: begin
          if (field_step(b, 4, v)) begin
            bpp = fmt_depth >> 3;
            if (bpp == 0) bpp = 1;
            data_left       = (v / bpp) * bpp;
            smp_acc         = 32'd0;
            ph              = (data_left == 32'd0) ? PH_DONE : PH_SAMPLES;
            r.kind          = KIND_FORMAT;
            r.channel_count = fmt_chans;
            r.rate_hz       = fmt_rate;
            r.depth_bits    = fmt_depth;
            hit             = 1'b1;
          end
        end
        PH_SAMPLES: begin
          bpp = fmt_depth >> 3;
          if (bpp == 0) bpp = 1;
          pos       = byte_idx;
          smp_acc   = smp_acc | (32'(b) << (8 * pos));
          data_left = data_left - 32'd1;
          if (pos + 1 >= bpp) begin
            n = smp_acc;
            // Byte samples get the fixed bias on top of the sign extension.
            if (fmt_depth == 6'd8) begin
              if (n[7]) n = n | 32'hffffff00;
              n = n + BYTE_BIAS;
            end else if (fmt_depth < 6'd32 && fmt_depth > 6'd0) begin
              if (n[fmt_depth-1]) n = n | (32'hffffffff << fmt_depth);
            end
            byte_idx      = 2'd0;
            smp_acc       = 32'd0;
            r.kind        = KIND_SAMPLE;
            r.sample_bits = n;
            hit           = 1'b1;
          end else begin
            byte_idx = 2'(pos + 1);
          end
          if (data_left == 32'd0) ph = PH_DONE;
        end
        default: ;
      endcase
    end
    if (last) begin
      // An unfinished file overrides whatever the final byte produced, unless it failed.
      if (!was_failed && !parse_failed && ph != PH_DONE) begin
        r   = flag_error(ERR_END);
        hit = 1'b1;
      end
      restart_parser();
    end
    if (hit) decoded_q.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Stimulus construction.
  function automatic void put_le(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_junk_chunk(input logic [31:0] alt_id);
    logic [31:0] id;
    int          len;
    id = {8'($urandom_range(97, 122)), 8'($urandom_range(97, 122)),
          8'($urandom_range(97, 122)), 8'($urandom_range(97, 122))};
    if ($urandom_range(0, 3) == 0) id = alt_id;
    len = $urandom_range(0, 6);
    put_le(id, 4);
    put_le(len, 4);
    repeat (len) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void flush_file();
    stream_byte_t sb;
    foreach (file_bytes[i]) begin
      sb.value = file_bytes[i];
      sb.last  = (i == file_bytes.size() - 1);
      sb.hold  = 1'b0;
      pending_bytes.push_back(sb);
    end
    file_bytes.delete();
  endfunction

  function automatic wav_spec_t random_spec();
    wav_spec_t s;
    s.riff_len     = $urandom;
    s.fmt_len      = FMT_CHUNK_SIZE;
    s.fmt_code     = 16'(PCM_FORMAT);
    s.chans        = 16'($urandom_range(1, 2));
    s.rate         = $urandom;
    s.depth        = 16'(8 * $urandom_range(1, 4));
    s.pre_chunks   = 0;
    s.mid_chunks   = 0;
    s.data_len     = $urandom_range(0, 32);
    s.data_present = s.data_len + $urandom_range(0, 3);
    s.extreme_fill = ($urandom_range(0, 3) == 0);
    s.cut_at       = 0;
    s.flip_at      = -1;
    return s;
  endfunction

  function automatic void emit_file(input wav_spec_t s);
    put_le(TAG_RIFF, 4);
    put_le(s.riff_len, 4);
    put_le(TAG_WAVE, 4);
    repeat (s.pre_chunks) put_junk_chunk(TAG_DATA);
    put_le(TAG_FMT, 4);
    put_le(s.fmt_len, 4);
    put_le(s.fmt_code, 2);
    put_le(s.chans, 2);
    put_le(s.rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(s.depth, 2);
    repeat (s.mid_chunks) put_junk_chunk(TAG_FMT);
    put_le(TAG_DATA, 4);
    put_le(s.data_len, 4);
    for (int i = 0; i < s.data_present; i++) begin
      if (s.extreme_fill) begin
        case ($urandom_range(0, 3))
          0: file_bytes.push_back(8'h00);
          1: file_bytes.push_back(8'h7f);
          2: file_bytes.push_back(8'h80);
          default: file_bytes.push_back(8'hff);
        endcase
      end else begin
        file_bytes.push_back(8'($urandom));
      end
    end
    if (s.cut_at > 0 && s.cut_at < file_bytes.size()) file_bytes = file_bytes[0:s.cut_at-1];
    if (s.flip_at >= 0 && s.flip_at < file_bytes.size())
      file_bytes[s.flip_at] = file_bytes[s.flip_at] ^ 8'($urandom_range(1, 255));
    flush_file();
  endfunction

  // Monitor, predictor feed and watchdog.
  always @(posedge clk) begin : monitor
    decoded_t want;
    logic     out_taken;
    if (!rst) begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (in_taken) decode_byte(in_byte, is_last);
      if (out_taken) begin
        if (decoded_q.size() == 0) begin
          $error("result item of kind %0d arrived with none expected", kind);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", want.kind, kind);
          check_field("sample_bits", want.sample_bits, sample_bits);
          check_field("channel_count", want.channel_count, channel_count);
          check_field("rate_hz", want.rate_hz, rate_hz);
          check_field("depth_bits", want.depth_bits, depth_bits);
          check_field("error_code", want.error_code, error_code);
        end
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("wav_pcm_stream_decoder: mismatch");
        $finish;
      end
    end
  end

  // Byte driver and output stall generator.
  always @(negedge clk) begin : driver
    stream_byte_t nxt;
    logic         may_idle;
    if (!rst) begin
      may_idle = (pending_bytes.size() >= QUIET_TAIL);
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0 && pending_bytes[0].hold) begin
          // Hold off until every predicted item has come out.
          in_valid <= 1'b0;
          if (decoded_q.size() == 0) void'(pending_bytes.pop_front());
        end else if (pending_bytes.size() > 0 && may_idle && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 8) - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.value;
          is_last  <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (may_idle && $urandom_range(0, 11) == 0) begin
        stall_gap = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    wav_spec_t s;
    int        pick;
    logic      mid_hold_done;
    restart_parser();
    mid_hold_done = 1'b0;

    // Directed files: sample extremes at every depth, chunk skipping, short and empty
    // data, early ends in the header and in the samples, and each error in the header.
    s = random_spec(); s.depth = 16'd8; s.chans = 16'd1; s.rate = 32'd0;
    s.data_len = 32'd6; s.data_present = 8; s.extreme_fill = 1'b1; emit_file(s);
    s = random_spec(); s.depth = 16'd16; s.chans = 16'd2; s.rate = 32'hffffffff;
    s.data_len = 32'd9; s.data_present = 9; s.extreme_fill = 1'b1; emit_file(s);
    s = random_spec(); s.depth = 16'd24; s.data_len = 32'd14; s.data_present = 14;
    s.extreme_fill = 1'b1; emit_file(s);
    s = random_spec(); s.depth = 16'd32; s.data_len = 32'd12; s.data_present = 13;
    s.extreme_fill = 1'b1; emit_file(s);
    s = random_spec(); s.pre_chunks = 2; s.mid_chunks = 2; s.riff_len = 32'd0; emit_file(s);
    s = random_spec(); s.data_len = 32'd0; s.data_present = 3; s.riff_len = 32'hffffffff;
    emit_file(s);
    s = random_spec(); s.depth = 16'd32; s.data_len = 32'd3; s.data_present = 3; emit_file(s);
    s = random_spec(); s.data_len = 32'hffffffff; s.data_present = 5; emit_file(s);
    s = random_spec(); s.data_len = 32'd4; s.data_present = 0; emit_file(s);
    s = random_spec(); s.depth = 16'd16; s.data_len = 32'd8; s.data_present = 8;
    s.cut_at = 46; emit_file(s);
    file_bytes.push_back(8'h00); flush_file();
    file_bytes.push_back(TAG_RIFF[7:0]); flush_file();
    s = random_spec(); s.flip_at = 0; emit_file(s);
    s = random_spec(); s.flip_at = 10; emit_file(s);
    s = random_spec(); s.fmt_len = 32'd18; emit_file(s);
    s = random_spec(); s.fmt_len = 32'hffffffff; emit_file(s);
    s = random_spec(); s.fmt_code = 16'd3; emit_file(s);
    s = random_spec(); s.fmt_code = 16'hffff; emit_file(s);
    s = random_spec(); s.chans = 16'd0; emit_file(s);
    s = random_spec(); s.chans = 16'd3; emit_file(s);
    s = random_spec(); s.chans = 16'hffff; s.cut_at = 24; emit_file(s);
    s = random_spec(); s.depth = 16'd0; emit_file(s);
    s = random_spec(); s.depth = 16'd12; emit_file(s);
    s = random_spec(); s.depth = 16'hffff; s.cut_at = 36; emit_file(s);
    pending_bytes.push_back('{value: 8'h00, last: 1'b0, hold: 1'b1});

    // Random files, mostly well formed, the rest broken or plain noise.
    while (pending_bytes.size() < ITEM_TARGET) begin
      if (!mid_hold_done && pending_bytes.size() >= ITEM_TARGET / 2) begin
        pending_bytes.push_back('{value: 8'h00, last: 1'b0, hold: 1'b1});
        mid_hold_done = 1'b1;
      end
      s = random_spec();
      if ($urandom_range(0, 3) == 0) s.pre_chunks = $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) s.mid_chunks = $urandom_range(1, 2);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        s.cut_at = $urandom_range(1, 70);
      end else if (pick < 20) begin
        s.flip_at = $urandom_range(0, 47);
      end else if (pick < 24) begin
        s.data_len     = $urandom;
        s.data_present = $urandom_range(0, 8);
      end else if (pick < 30) begin
        case ($urandom_range(0, 3))
          0: s.fmt_len = $urandom;
          1: s.fmt_code = 16'($urandom);
          2: s.chans = 16'($urandom);
          default: s.depth = 16'($urandom);
        endcase
      end
      if (pick >= 95) begin
        repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
        flush_file();
      end else begin
        emit_file(s);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_bytes.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("wav_pcm_stream_decoder: match");
    end else begin
      $display("wav_pcm_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wpsd_pkg.sv
src/wpsd_core.sv
src/wav_pcm_stream_decoder.sv
test/wav_pcm_stream_decoder_tb.sv
